// ===== hdl/icmp_erb_pkg.sv =====
// ----------------------------------------------------------------------------
// ICMP echo reply builder package
// Record types, status codes, frame offsets and the ones-complement adder
// shared by the parser, the result queue and the top level.
// ----------------------------------------------------------------------------
package icmp_erb_pkg;

   typedef enum logic [1:0] {
      ST_REPLY     = 2'd0,
      ST_NON_ECHO  = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_TOO_LARGE = 2'd3
   } status_type;

   typedef enum logic {
      KIND_BYTE    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   // One result record as it leaves the block.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  reply_byte;
      status_type  status;
      logic [31:0] dest_address;
      logic [15:0] reply_checksum;
      logic [10:0] reply_length;
      logic        end_marker;
   } rec_type;

   // Records produced by one accepted byte: none, one or two.
   typedef struct packed {
      logic [1:0] count;
      rec_type    first;
      rec_type    second;
   } push_type;

   // Frame offsets (Ethernet header is 14 bytes).
   localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
   localparam logic [15:0] IHL_POS        = 16'd14;
   localparam logic [15:0] TLEN_HI_POS    = 16'd16;
   localparam logic [15:0] TLEN_LO_POS    = 16'd17;
   localparam logic [15:0] SRC_FIRST_POS  = 16'd26;
   localparam logic [15:0] SRC_LAST_POS   = 16'd29;
   localparam logic [15:0] POS_MAX        = 16'hFFFF;
   localparam logic [5:0]  IPV4_MIN_HDR   = 6'd20;
   localparam logic [16:0] MIN_FRAME_LEN  = 17'd42;
   localparam logic [7:0]  ECHO_REQUEST   = 8'd8;
   localparam logic [15:0] ICMP_ZERO_LEN  = 16'd4;
   localparam int unsigned ETH_IP_HDR_SUM = 34;

   // Result queue.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Ones-complement 16-bit add with end-around carry.
   function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      begin
         s = {1'b0, acc} + {1'b0, word};
         csum_add = s[15:0] + {15'b0, s[16]};
      end
   endfunction

endpackage

// ===== hdl/icmp_erb_parser.sv =====
// ----------------------------------------------------------------------------
// ICMP echo reply builder: frame parser
// Tracks the byte position, captures the IPv4 header fields, streams reply
// bytes with a running checksum and builds the end-of-frame summary record.
// ----------------------------------------------------------------------------
module icmp_erb_parser
   import icmp_erb_pkg::*;
#(
   parameter int unsigned FRAME_MAX = 1536
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output push_type   push
);

   localparam logic [16:0] REPLY_MAX = 17'(FRAME_MAX - ETH_IP_HDR_SUM);

   logic [15:0] pos_ff,  pos_in;
   logic [5:0]  hl_ff,   hl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [31:0] src_ff,  src_in;
   logic        echo_ff, echo_in;
   logic [15:0] sum_ff,  sum_in;
   logic [7:0]  hold_ff, hold_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hl_ff   <= '0;
         tlen_ff <= '0;
         src_ff  <= '0;
         echo_ff <= 1'b0;
         sum_ff  <= '0;
         hold_ff <= '0;
      end else if (fire) begin
         if (last_byte) begin
            pos_ff  <= '0;
            hl_ff   <= '0;
            tlen_ff <= '0;
            src_ff  <= '0;
            echo_ff <= 1'b0;
            sum_ff  <= '0;
            hold_ff <= '0;
         end else begin
            pos_ff  <= pos_in;
            hl_ff   <= hl_in;
            tlen_ff <= tlen_in;
            src_ff  <= src_in;
            echo_ff <= echo_in;
            sum_ff  <= sum_in;
            hold_ff <= hold_in;
         end
      end
   end

   always_comb begin
      logic [15:0] start;
      logic [16:0] stop;
      logic [15:0] off;
      logic [7:0]  ob;
      logic        stream;
      logic [16:0] len;
      logic [15:0] rlen;
      logic [15:0] sum_fin;
      status_type  status;
      rec_type     byte_rec;
      rec_type     sum_rec;

      hl_in   = hl_ff;
      tlen_in = tlen_ff;
      src_in  = src_ff;
      echo_in = echo_ff;
      sum_in  = sum_ff;
      hold_in = hold_ff;
      pos_in  = (pos_ff != POS_MAX) ? pos_ff + 16'd1 : pos_ff;

      // Header capture happens before the stream check, as both use it.
      if (pos_ff == IHL_POS) begin
         hl_in = {data_byte[3:0], 2'b00};
      end else if (pos_ff == TLEN_HI_POS) begin
         tlen_in = {data_byte, tlen_ff[7:0]};
      end else if (pos_ff == TLEN_LO_POS) begin
         tlen_in = {tlen_ff[15:8], data_byte};
      end else if (pos_ff >= SRC_FIRST_POS && pos_ff <= SRC_LAST_POS) begin
         src_in = {src_ff[23:0], data_byte};
      end

      start  = {9'b0, ETH_HDR_LEN} + {10'b0, hl_in};
      stop   = {10'b0, ETH_HDR_LEN} + {1'b0, tlen_in};
      off    = pos_ff - start;
      ob     = (off < ICMP_ZERO_LEN) ? 8'h00 : data_byte;
      stream = 1'b0;

      if (pos_ff != POS_MAX && hl_in >= IPV4_MIN_HDR) begin
         if (pos_ff == start) begin
            echo_in = (data_byte == ECHO_REQUEST);
         end
         if (echo_in && pos_ff >= start && {1'b0, pos_ff} < stop) begin
            stream = 1'b1;
            if (!off[0]) begin
               hold_in = ob;
            end else begin
               sum_in = csum_add(sum_ff, {hold_ff, ob});
            end
         end
      end

      // Summary record; a saturated position counts as 65536 bytes.
      len     = {1'b0, pos_ff} + 17'd1;
      rlen    = tlen_in - {10'b0, hl_in};
      sum_fin = rlen[0] ? csum_add(sum_in, {hold_in, 8'h00}) : sum_in;
      if (len < MIN_FRAME_LEN || hl_in < IPV4_MIN_HDR || stop > len
          || tlen_in <= {10'b0, hl_in}) begin
         status = ST_MALFORMED;
      end else if (!echo_in) begin
         status = ST_NON_ECHO;
      end else if ({1'b0, rlen} > REPLY_MAX) begin
         status = ST_TOO_LARGE;
      end else begin
         status = ST_REPLY;
      end

      byte_rec            = '0;
      byte_rec.kind       = KIND_BYTE;
      byte_rec.reply_byte = ob;

      sum_rec              = '0;
      sum_rec.kind         = KIND_SUMMARY;
      sum_rec.status       = status;
      sum_rec.dest_address = src_in;
      sum_rec.end_marker   = 1'b1;
      if (status == ST_REPLY) begin
         sum_rec.reply_checksum = ~sum_fin;
         sum_rec.reply_length   = rlen[10:0];
      end

      push = '0;
      if (fire) begin
         priority if (stream && last_byte) begin
            push.count  = 2'd2;
            push.first  = byte_rec;
            push.second = sum_rec;
         end else if (stream) begin
            push.count = 2'd1;
            push.first = byte_rec;
         end else if (last_byte) begin
            push.count = 2'd1;
            push.first = sum_rec;
         end else begin
            push.count = 2'd0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && last_byte |=> pos_ff == '0 && sum_ff == '0 && !echo_ff)
      else $error("frame state not cleared after the final byte");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.kind == KIND_BYTE
                             && push.second.kind == KIND_SUMMARY)
      else $error("reply byte must precede the summary record");

   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      !fire |-> push.count == 2'd0)
      else $error("records produced without an accepted byte");

   a_fail_zero_len: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 && push.first.kind == KIND_SUMMARY
      && push.first.status != ST_REPLY |-> push.first.reply_length == '0
                                          && push.first.reply_checksum == '0)
      else $error("failed frame carries a length or checksum");
`endif

endmodule

// ===== hdl/icmp_erb_queue.sv =====
// ----------------------------------------------------------------------------
// ICMP echo reply builder: result queue
// Small register queue that takes up to two records per cycle and hands one
// record per cycle to the result channel while out_ready is high.
// ----------------------------------------------------------------------------
module icmp_erb_queue
   import icmp_erb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space_two,
   output logic     out_valid,
   input  logic     out_ready,
   output rec_type  out_rec
);

   rec_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                pop;

   assign out_valid = (count_ff != '0);
   assign out_rec   = slot_ff[rd_ptr_ff];
   assign space_two = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= QCNT_W'(QUEUE_DEPTH - 2))
      else $error("record pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && push.count == 2'd0 |=> count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("queue count wrong after a pop");
`endif

endmodule

// ===== hdl/icmp_echo_reply_builder.sv =====
// ----------------------------------------------------------------------------
// ICMP echo reply builder
// Parses an Ethernet/IPv4/ICMP frame one byte per transaction and streams
// the echo reply payload followed by a summary record per frame.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_ready | data_byte, last_byte
//   rsp     | out       | rsp_valid/rsp_ready | record_kind .. end_marker
//
// One input byte is taken per cycle when ready; the summary record of the
// final byte may follow a reply byte, so that byte yields two output
// transactions. The parser state updates in the cycle a byte is accepted
// and the records land in a four-entry queue; rsp_valid rises in the cycle
// after acceptance. req_ready drops only while the queue holds more than
// two records. Synchronous reset clears frame state and empties the queue.
// ----------------------------------------------------------------------------
module icmp_echo_reply_builder
   import icmp_erb_pkg::*;
#(
   parameter int unsigned FRAME_MAX = 1536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [7:0]  rsp_reply_byte,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_dest_address,
   output logic [15:0] rsp_reply_checksum,
   output logic [10:0] rsp_reply_length,
   output logic        rsp_end_marker
);

   push_type push;
   rec_type  head;
   logic     space_two;
   logic     fire;

   assign req_ready = space_two;
   assign fire      = req_valid && req_ready;

   icmp_erb_parser #(
      .FRAME_MAX (FRAME_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push)
   );

   icmp_erb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_two (space_two),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rec   (head)
   );

   assign rsp_record_kind    = head.kind;
   assign rsp_reply_byte     = head.reply_byte;
   assign rsp_status         = head.status;
   assign rsp_dest_address   = head.dest_address;
   assign rsp_reply_checksum = head.reply_checksum;
   assign rsp_reply_length   = head.reply_length;
   assign rsp_end_marker     = head.end_marker;

endmodule

// ===== verif/icmp_reply_checker.sv =====
// ----------------------------------------------------------------------------
// ICMP echo reply checker
// Watches the byte stream into the echo reply builder, predicts the reply
// bytes and the end-of-frame summary of every frame, and compares each
// transaction on the result channel with the oldest prediction.
// ----------------------------------------------------------------------------
module icmp_reply_checker
   import icmp_erb_pkg::*;
#(
   parameter int unsigned FRAME_MAX = 1536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_record_kind,
   input  logic [7:0]  rsp_reply_byte,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_dest_address,
   input  logic [15:0] rsp_reply_checksum,
   input  logic [10:0] rsp_reply_length,
   input  logic        rsp_end_marker,
   output int          mismatches,
   output int          records_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAC_HDR_BYTES   = 14;
   localparam int unsigned IHL_OFFSET      = 14;
   localparam int unsigned TLEN_HI_OFFSET  = 16;
   localparam int unsigned TLEN_LO_OFFSET  = 17;
   localparam int unsigned SRC_OFFSET      = 26;
   localparam int unsigned IP_HDR_MIN      = 20;
   localparam int unsigned MIN_FRAME_BYTES = 42;
   localparam int unsigned ICMP_HDR_ZEROED = 4;
   localparam int unsigned POS_SATURATED   = 16'hFFFF;
   localparam int unsigned REPLY_MAX       = FRAME_MAX - MAC_HDR_BYTES - IP_HDR_MIN;

   // Frame parser state.
   logic [15:0] frame_pos;
   logic [5:0]  hdr_bytes;
   logic [15:0] total_len;
   logic [31:0] src_addr;
   logic        echo_seen;
   logic [15:0] running_sum;
   logic [7:0]  held_byte;

   rec_type reply_records_due[$];
   rec_type oldest_due;
   int      error_total = 0;

   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
      int unsigned s;
      s = int'(acc) + int'(word);
      s = (s & 32'hFFFF) + (s >> 16);
      return s[15:0];
   endfunction

   task automatic clear_frame_state();
      frame_pos   = '0;
      hdr_bytes   = '0;
      total_len   = '0;
      src_addr    = '0;
      echo_seen   = 1'b0;
      running_sum = '0;
      held_byte   = '0;
   endtask

   task automatic parse_frame_byte(input logic [7:0] b, input logic last);
      int unsigned pos, start, stop, offset, len, ihl, tlen, rlen;
      logic [7:0]  ob;
      logic [15:0] ck;
      status_type  st;
      rec_type     rec;
      pos = frame_pos;
      if (pos == IHL_OFFSET) hdr_bytes = {b[3:0], 2'b00};
      else if (pos == TLEN_HI_OFFSET) total_len[15:8] = b;
      else if (pos == TLEN_LO_OFFSET) total_len[7:0] = b;
      else if (pos >= SRC_OFFSET && pos < SRC_OFFSET + 4) src_addr = {src_addr[23:0], b};

      if (pos < POS_SATURATED && hdr_bytes >= IP_HDR_MIN) begin
         start = MAC_HDR_BYTES + hdr_bytes;
         stop  = MAC_HDR_BYTES + total_len;
         if (pos == start) echo_seen = (b == ECHO_REQUEST);
         if (echo_seen && pos >= start && pos < stop) begin
            offset = pos - start;
            // Type, code and checksum of the reply go out as zero.
            ob = (offset < ICMP_HDR_ZEROED) ? 8'h00 : b;
            if (offset % 2 == 0) held_byte = ob;
            else running_sum = ones_add(running_sum, {held_byte, ob});
            rec = '0;
            rec.kind = KIND_BYTE;
            rec.reply_byte = ob;
            reply_records_due.push_back(rec);
         end
      end

      if (pos < POS_SATURATED) frame_pos = frame_pos + 16'd1;

      if (last) begin
         len  = pos + 1;
         ihl  = hdr_bytes;
         tlen = total_len;
         ck   = '0;
         rlen = 0;
         // Lengths are compared at full width, so a total length near the
         // 16-bit limit cannot wrap into range.
         if (len < MIN_FRAME_BYTES || ihl < IP_HDR_MIN ||
             MAC_HDR_BYTES + tlen > len || tlen <= ihl) begin
            st = ST_MALFORMED;
         end else if (!echo_seen) begin
            st = ST_NON_ECHO;
         end else if (tlen - ihl > REPLY_MAX) begin
            st = ST_TOO_LARGE;
         end else begin
            st = ST_REPLY;
            rlen = tlen - ihl;
            if (rlen % 2 == 1) running_sum = ones_add(running_sum, {held_byte, 8'h00});
            ck = ~running_sum;
         end
         rec = '0;
         rec.kind = KIND_SUMMARY;
         rec.status = st;
         rec.dest_address = src_addr;
         rec.reply_checksum = ck;
         rec.reply_length = rlen[10:0];
         rec.end_marker = 1'b1;
         reply_records_due.push_back(rec);
         clear_frame_state();
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame_state();
         reply_records_due.delete();
      end else begin
         // A record leaves at the earliest in the cycle after its byte was taken,
         // so the output side is checked before this cycle's byte is parsed.
         if (rsp_valid && rsp_ready) begin
            if (reply_records_due.size() == 0) begin
               $display("%0t: unexpected record, expected none, actual kind %0d byte 0x%0h",
                        $time, rsp_record_kind, rsp_reply_byte);
               error_total++;
            end else begin
               oldest_due = reply_records_due.pop_front();
               compare_field("record_kind", 32'(oldest_due.kind), 32'(rsp_record_kind));
               compare_field("reply_byte", 32'(oldest_due.reply_byte), 32'(rsp_reply_byte));
               compare_field("status", 32'(oldest_due.status), 32'(rsp_status));
               compare_field("dest_address", oldest_due.dest_address, rsp_dest_address);
               compare_field("reply_checksum", 32'(oldest_due.reply_checksum),
                             32'(rsp_reply_checksum));
               compare_field("reply_length", 32'(oldest_due.reply_length),
                             32'(rsp_reply_length));
               compare_field("end_marker", 32'(oldest_due.end_marker), 32'(rsp_end_marker));
            end
         end
         if (req_valid && req_ready) parse_frame_byte(req_data_byte, req_last_byte);
      end
      records_pending <= reply_records_due.size();
      mismatches      <= error_total;
   end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// ICMP echo reply builder testbench
// Feeds Ethernet/IPv4/ICMP frames byte by byte, directed corner frames first
// and then random well-formed and broken frames, under changing idle rates
// on both channels and one long output stall. The checker beside the block
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module testbench
   import icmp_erb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_MAX      = 1536;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          HOLD_CYCLES    = 300;
   localparam int unsigned RANDOM_BYTES   = 220;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_record_kind;
   logic [7:0]  rsp_reply_byte;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_dest_address;
   logic [15:0] rsp_reply_checksum;
   logic [10:0] rsp_reply_length;
   logic        rsp_end_marker;

   int mismatches;
   int records_pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_requested = 1'b0;
   int hold_count = 0;
   int quiet_cycles = 0;
   int unsigned phase_bytes;
   int unsigned frame_bytes;

   icmp_echo_reply_builder #(.FRAME_MAX(FRAME_MAX)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_status         (rsp_status),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_reply_checksum (rsp_reply_checksum),
      .rsp_reply_length   (rsp_reply_length),
      .rsp_end_marker     (rsp_end_marker)
   );

   icmp_reply_checker #(.FRAME_MAX(FRAME_MAX)) reply_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_reply_byte     (rsp_reply_byte),
      .rsp_status         (rsp_status),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_reply_checksum (rsp_reply_checksum),
      .rsp_reply_length   (rsp_reply_length),
      .rsp_end_marker     (rsp_end_marker),
      .mismatches         (mismatches),
      .records_pending    (records_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random back-pressure, plus one long hold-off once requested.
   always @(negedge clock) begin
      if (hold_requested && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // A negative fill gives random filler bytes, otherwise every byte that is
   // not a header field of interest takes the fill value.
   task automatic send_frame(input int unsigned frame_len, input logic [3:0] ihl_words,
                             input logic [15:0] ip_len, input logic [7:0] icmp_type,
                             input int fill);
      int unsigned i;
      int unsigned type_pos;
      logic [7:0]  b;
      type_pos = 14 + 4 * int'(ihl_words);
      for (i = 0; i < frame_len; i++) begin
         b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         if (i == 14) b[3:0] = ihl_words;
         else if (i == 16) b = ip_len[15:8];
         else if (i == 17) b = ip_len[7:0];
         else if (i == type_pos && ihl_words >= 4'd5) b = icmp_type;
         send_byte(b, i == frame_len - 1);
      end
   endtask

   task automatic send_random_frame(output int unsigned sent);
      int unsigned pick, payload_len, frame_len;
      logic [3:0]  ihl_words;
      logic [15:0] ip_len;
      logic [7:0]  icmp_type;
      pick        = $urandom_range(0, 99);
      ihl_words   = 4'($urandom_range(5, 15));
      payload_len = $urandom_range(8, 48);
      ip_len      = 16'(4 * int'(ihl_words) + payload_len);
      frame_len   = 14 + ip_len + $urandom_range(0, 6);
      icmp_type   = ECHO_REQUEST;
      if (pick >= 70 && pick < 78) begin
         icmp_type = 8'($urandom_range(0, 255));
      end else if (pick >= 78 && pick < 85) begin
         ihl_words = 4'($urandom_range(0, 4));
      end else if (pick >= 85 && pick < 92) begin
         frame_len = $urandom_range(1, 14 + ip_len - 1);
      end else if (pick >= 92) begin
         ip_len = 16'($urandom_range(0, 65535));
      end
      send_frame(frame_len, ihl_words, ip_len, icmp_type, -1);
      sent = frame_len;
   endtask

   task automatic run_random(input int unsigned budget);
      phase_bytes = 0;
      while (phase_bytes < budget) begin
         send_random_frame(frame_bytes);
         phase_bytes += frame_bytes;
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      recv_idle_pct = 87;
      send_frame(42, 4'd5, 16'd28, ECHO_REQUEST, -1);
      send_frame(60, 4'd5, 16'd29, ECHO_REQUEST, -1);
      send_frame(74, 4'd15, 16'd69, ECHO_REQUEST, -1);
      send_frame(64, 4'd5, 16'd50, ECHO_REQUEST, 255);
      send_frame(64, 4'd5, 16'd50, ECHO_REQUEST, 0);
      send_frame(60, 4'd5, 16'd40, 8'h00, -1);
      send_frame(60, 4'd5, 16'd40, 8'hFF, -1);
      send_frame(60, 4'd4, 16'd40, ECHO_REQUEST, -1);
      send_frame(60, 4'd0, 16'd40, ECHO_REQUEST, -1);
      send_frame(41, 4'd5, 16'd27, ECHO_REQUEST, -1);
      send_frame(1, 4'd5, 16'd28, ECHO_REQUEST, -1);
      send_frame(16, 4'd5, 16'd28, ECHO_REQUEST, -1);
      // The total length runs past the end of the frame: bytes stream, then
      // the summary flags the frame as malformed.
      send_frame(50, 4'd5, 16'd60, ECHO_REQUEST, -1);
      send_frame(60, 4'd5, 16'd20, ECHO_REQUEST, -1);
      send_frame(60, 4'd5, 16'd10, ECHO_REQUEST, -1);
      send_frame(60, 4'd5, 16'hFFFF, ECHO_REQUEST, -1);
      run_random(RANDOM_BYTES);

      send_idle_pct = 87;
      recv_idle_pct = 32;
      run_random(RANDOM_BYTES);

      // No idling; the receiver holds off for a while so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requested <= 1'b1;
      run_random(RANDOM_BYTES);
      req_valid <= 1'b0;

      while (records_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== icmp_echo_reply_builder.f =====
hdl/icmp_erb_pkg.sv
hdl/icmp_erb_parser.sv
hdl/icmp_erb_queue.sv
hdl/icmp_echo_reply_builder.sv
verif/icmp_reply_checker.sv
verif/testbench.sv
